@@ sv/mmcc_pkg.sv @@
// Shared constants, codes and command/status types for the mesh mapping cost block.
`timescale 1ns / 1ps
package mmcc_pkg;

  localparam int TASK_W      = 7;
  localparam int LOAD_W      = 6;
  localparam int CORE_W      = 6;
  localparam int CFG_W       = 7;
  localparam int VOLUME_W    = 16;
  localparam int COST_W      = 32;
  localparam int DIST_W      = CORE_W + 2;
  localparam int PROD_W      = DIST_W + VOLUME_W;
  localparam int CORE_CMP_W  = 11;

  localparam int MAX_TASKS   = 64;
  localparam int MAX_CORES   = 64;
  localparam int VOLUME_BITS = 16;
  localparam int TABLE_LIMIT = 2 ** LOAD_W;

  localparam int VOL_USED = (VOLUME_BITS < VOLUME_W) ? VOLUME_BITS : VOLUME_W;
  localparam logic [VOLUME_W-1:0] VOL_MASK =
    VOLUME_W'((VOLUME_W+1)'(1) << VOL_USED) - VOLUME_W'(1);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] COLS_RST  = 7'd4;
  localparam logic [CFG_W-1:0] CORES_RST = 7'd16;
  localparam logic [CFG_W-1:0] TASKS_RST = 7'd16;

  typedef enum logic [1:0] {
    REG_MESH_COLUMNS = 2'd0,
    REG_CORE_COUNT   = 2'd1,
    REG_TASK_COUNT   = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EDGE = 1'b1
  } command_t;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic lookup;
    logic div_start;
    logic div_step;
    logic mul;
    logic acc;
  } dp_cmd_t;

  typedef struct packed {
    logic in_edge;
    logic task_bad;
    logic last;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/mmcc_if.sv @@
// Item channel interfaces: edge/load input and cost result output.
`timescale 1ns / 1ps
interface mmcc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [mmcc_pkg::LOAD_W-1:0]   load_task;
  logic [mmcc_pkg::CORE_W-1:0]   load_core;
  logic [mmcc_pkg::TASK_W-1:0]   source_task;
  logic [mmcc_pkg::TASK_W-1:0]   target_task;
  logic [mmcc_pkg::VOLUME_W-1:0] volume;
  logic                         last_edge;

  modport source (output valid, command, load_task, load_core, source_task, target_task,
                  volume, last_edge, input ready);
  modport sink (input valid, command, load_task, load_core, source_task, target_task,
                volume, last_edge, output ready);
endinterface

interface mmcc_out_if;
  logic                       valid;
  logic                       ready;
  logic [mmcc_pkg::COST_W-1:0] total_cost;
  logic                       index_error;
  logic                       cost_saturated;

  modport source (output valid, total_cost, index_error, cost_saturated, input ready);
  modport sink (input valid, total_cost, index_error, cost_saturated, output ready);
endinterface

@@ sv/mmcc_div.sv @@
// Restoring divider, one quotient bit per cycle while step is high, for core row and column.
`timescale 1ns / 1ps
module mmcc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        step,
  input  logic [mmcc_pkg::CORE_W-1:0] dividend,
  input  logic [mmcc_pkg::CFG_W-1:0]  divisor,
  output logic [mmcc_pkg::CORE_W-1:0] quot,
  output logic [mmcc_pkg::CFG_W-1:0]  rem,
  output logic                        done
);

  localparam int CNT_W = $clog2(mmcc_pkg::CORE_W + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(mmcc_pkg::CORE_W);

  logic [mmcc_pkg::CFG_W-1:0]  rem_r, rem_nxt;
  logic [mmcc_pkg::CORE_W-1:0] dq_r, dq_nxt;
  logic [mmcc_pkg::CFG_W-1:0]  dvs_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [mmcc_pkg::CFG_W:0]    trial;
  logic                        ge;

  assign trial = {rem_r, dq_r[mmcc_pkg::CORE_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt = ge ? mmcc_pkg::CFG_W'(trial - {1'b0, dvs_r}) : trial[mmcc_pkg::CFG_W-1:0];
    dq_nxt  = {dq_r[mmcc_pkg::CORE_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_END;
    end else if (start) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
    end else if (step) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign quot = dq_r;
  assign rem  = rem_r;
  assign done = (cnt_r == CNT_END);

endmodule

@@ sv/mmcc_dp.sv @@
// Datapath: placement table, task/core checks, dividers, multiply and saturating total.
`timescale 1ns / 1ps
module mmcc_dp #(
  parameter int MAX_TASKS = mmcc_pkg::MAX_TASKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmcc_pkg::dp_cmd_t             cmd,
  output mmcc_pkg::dp_status_t          status,
  input  logic                          in_command,
  input  logic [mmcc_pkg::LOAD_W-1:0]   in_load_task,
  input  logic [mmcc_pkg::CORE_W-1:0]   in_load_core,
  input  logic [mmcc_pkg::TASK_W-1:0]   in_source_task,
  input  logic [mmcc_pkg::TASK_W-1:0]   in_target_task,
  input  logic [mmcc_pkg::VOLUME_W-1:0] in_volume,
  input  logic                          in_last_edge,
  input  logic [mmcc_pkg::CFG_W-1:0]    mesh_columns,
  input  logic [mmcc_pkg::CFG_W-1:0]    core_count,
  input  logic [mmcc_pkg::CFG_W-1:0]    task_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mmcc_pkg::COST_W-1:0]   out_total_cost,
  output logic                          out_index_error,
  output logic                          out_cost_saturated
);

  localparam int DEPTH = (MAX_TASKS < mmcc_pkg::TABLE_LIMIT) ? MAX_TASKS : mmcc_pkg::TABLE_LIMIT;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [mmcc_pkg::TASK_W-1:0] DEPTH_T = mmcc_pkg::TASK_W'(DEPTH);

  logic [mmcc_pkg::CORE_W-1:0]   table_mem [DEPTH];

  logic [IDX_W-1:0]              src_idx_r, dst_idx_r;
  logic                          task_bad_r, last_r;
  logic [mmcc_pkg::VOLUME_W-1:0] vol_r;
  logic [mmcc_pkg::CORE_W-1:0]   pe1_r, pe2_r;
  logic [mmcc_pkg::PROD_W-1:0]   prod_r;
  logic [mmcc_pkg::COST_W-1:0]   acc_r, acc_nxt;
  logic                          err_seen_r, err_nxt;
  logic                          ovf_seen_r, ovf_nxt;
  logic                          out_valid_r;
  logic [mmcc_pkg::COST_W-1:0]   out_total_r;
  logic                          out_err_r, out_ovf_r;

  logic                          load_ok;
  logic [mmcc_pkg::CFG_W-1:0]    cols_eff;
  logic [mmcc_pkg::CORE_W-1:0]   q1, q2, qd;
  logic [mmcc_pkg::CFG_W-1:0]    r1, r2, rd;
  logic                          d1, d2;
  logic [mmcc_pkg::DIST_W-1:0]   hop_dist;
  logic                          core_bad;
  logic [mmcc_pkg::COST_W:0]     sum;

  function automatic logic task_ok(input logic [mmcc_pkg::TASK_W-1:0] t,
                                   input logic [mmcc_pkg::CFG_W-1:0]  cnt);
    return (t != '0) && (t <= cnt) && (t <= DEPTH_T);
  endfunction

  function automatic logic [IDX_W-1:0] task_idx(input logic [mmcc_pkg::TASK_W-1:0] t);
    return IDX_W'(mmcc_pkg::TASK_W'(t - mmcc_pkg::TASK_W'(1)));
  endfunction

  assign load_ok = {1'b0, in_load_task} < DEPTH_T;

  // Placement table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      table_mem[IDX_W'(in_load_task)] <= in_load_core;
    end
    if (cmd.lookup) begin
      pe1_r <= table_mem[src_idx_r];
      pe2_r <= table_mem[dst_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src_idx_r  <= task_idx(in_source_task);
      dst_idx_r  <= task_idx(in_target_task);
      task_bad_r <= !(task_ok(in_source_task, task_count) &&
                      task_ok(in_target_task, task_count));
      last_r     <= in_last_edge;
      vol_r      <= in_volume & mmcc_pkg::VOL_MASK;
    end
  end

  assign cols_eff = (mesh_columns == '0) ? mmcc_pkg::CFG_W'(1) : mesh_columns;

  mmcc_div u_div_src (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (pe1_r),
    .divisor  (cols_eff),
    .quot     (q1),
    .rem      (r1),
    .done     (d1)
  );

  mmcc_div u_div_dst (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (pe2_r),
    .divisor  (cols_eff),
    .quot     (q2),
    .rem      (r2),
    .done     (d2)
  );

  always_comb begin
    qd       = (q1 > q2) ? (q1 - q2) : (q2 - q1);
    rd       = (r1 > r2) ? (r1 - r2) : (r2 - r1);
    hop_dist = mmcc_pkg::DIST_W'(qd) + mmcc_pkg::DIST_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= mmcc_pkg::PROD_W'(hop_dist) * mmcc_pkg::PROD_W'(vol_r);
    end
  end

  assign core_bad =
    ({1'b0, pe1_r} >= core_count) || ({1'b0, pe2_r} >= core_count) ||
    (mmcc_pkg::CORE_CMP_W'(pe1_r) >= mmcc_pkg::CORE_CMP_W'(mmcc_pkg::MAX_CORES)) ||
    (mmcc_pkg::CORE_CMP_W'(pe2_r) >= mmcc_pkg::CORE_CMP_W'(mmcc_pkg::MAX_CORES));

  assign sum = {1'b0, acc_r} + (mmcc_pkg::COST_W+1)'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    err_nxt = err_seen_r;
    ovf_nxt = ovf_seen_r;
    if (task_bad_r || core_bad) begin
      err_nxt = 1'b1;
    end else if (sum[mmcc_pkg::COST_W]) begin
      acc_nxt = '1;
      ovf_nxt = 1'b1;
    end else begin
      acc_nxt = sum[mmcc_pkg::COST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      err_seen_r  <= 1'b0;
      ovf_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc) begin
        if (last_r) begin
          acc_r      <= '0;
          err_seen_r <= 1'b0;
          ovf_seen_r <= 1'b0;
        end else begin
          acc_r      <= acc_nxt;
          err_seen_r <= err_nxt;
          ovf_seen_r <= ovf_nxt;
        end
      end
      if (cmd.acc && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && last_r) begin
      out_total_r <= acc_nxt;
      out_err_r   <= err_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_total_cost     = out_total_r;
  assign out_index_error    = out_err_r;
  assign out_cost_saturated = out_ovf_r;

  always_comb begin
    status.in_edge  = (mmcc_pkg::command_t'(in_command) == mmcc_pkg::CMD_EDGE);
    status.task_bad = task_bad_r;
    status.last     = last_r;
    status.div_done = d1;
    status.out_free = !out_valid_r || out_ready;
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc && last_r |=> acc_r == '0 && !err_seen_r && !ovf_seen_r)
    else $error("total not cleared after last edge");

  a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_seen_r |-> acc_r == '1)
    else $error("saturation flag without clamped total");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    d1 == d2)
    else $error("dividers out of step");

endmodule

@@ sv/mmcc_ctrl.sv @@
// Controller: sequences lookup, division, multiply and accumulate for each edge item.
`timescale 1ns / 1ps
module mmcc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mmcc_pkg::dp_status_t status,
  output mmcc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOKUP = 6'b000010,
    S_PREP   = 6'b000100,
    S_DIV    = 6'b001000,
    S_ACC    = 6'b010000,
    S_SPARE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (status.in_edge) begin
            state_nxt = S_LOOKUP;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = status.task_bad ? S_ACC : S_PREP;
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.mul   = 1'b1;
          state_nxt = S_ACC;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_ACC: begin
        if (!status.last || status.out_free) begin
          cmd.acc   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_edge_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture && status.in_edge |=> state_r == S_LOOKUP)
    else $error("edge item did not start a lookup");

  a_acc_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |=> state_r == S_IDLE && !cmd.acc)
    else $error("accumulate not followed by idle");

endmodule

@@ sv/mesh_mapping_comm_cost.sv @@
// Top level: mesh mapping communication cost scorer with APB configuration.
// Load items: one per cycle while idle, no result. Edge items: capture, lookup, divider start,
// six-step bit-serial row/column division, accumulate, then the next accept (a bad task number
// skips to accumulate). The result is valid after the last edge accumulates; a held result
// stalls only the next last edge. Reset (rst_n, synchronous, active low) clears total,
// flags and control, sets registers to 4/16/16; the placement table is not cleared.
`timescale 1ns / 1ps
module mesh_mapping_comm_cost #(
  parameter int MAX_TASKS = mmcc_pkg::MAX_TASKS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mmcc_in_if.sink                     in_chan,
  mmcc_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mmcc_pkg::APB_AW-1:0] paddr,
  input  logic [mmcc_pkg::APB_DW-1:0] pwdata,
  output logic [mmcc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  logic [mmcc_pkg::CFG_W-1:0] mesh_columns_r, core_count_r, task_count_r;
  logic                       cfg_wr;
  mmcc_pkg::reg_idx_t         cfg_idx;
  mmcc_pkg::dp_cmd_t          cmd;
  mmcc_pkg::dp_status_t       status;
  logic                       in_ready;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = mmcc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_columns_r <= mmcc_pkg::COLS_RST;
      core_count_r   <= mmcc_pkg::CORES_RST;
      task_count_r   <= mmcc_pkg::TASKS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mmcc_pkg::REG_MESH_COLUMNS: mesh_columns_r <= pwdata[mmcc_pkg::CFG_W-1:0];
        mmcc_pkg::REG_CORE_COUNT:   core_count_r   <= pwdata[mmcc_pkg::CFG_W-1:0];
        mmcc_pkg::REG_TASK_COUNT:   task_count_r   <= pwdata[mmcc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mmcc_pkg::REG_MESH_COLUMNS: prdata = mmcc_pkg::APB_DW'(mesh_columns_r);
      mmcc_pkg::REG_CORE_COUNT:   prdata = mmcc_pkg::APB_DW'(core_count_r);
      mmcc_pkg::REG_TASK_COUNT:   prdata = mmcc_pkg::APB_DW'(task_count_r);
      default:                    prdata = '0;
    endcase
  end

  mmcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_chan.ready = in_ready;

  mmcc_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_command         (in_chan.command),
    .in_load_task       (in_chan.load_task),
    .in_load_core       (in_chan.load_core),
    .in_source_task     (in_chan.source_task),
    .in_target_task     (in_chan.target_task),
    .in_volume          (in_chan.volume),
    .in_last_edge       (in_chan.last_edge),
    .mesh_columns       (mesh_columns_r),
    .core_count         (core_count_r),
    .task_count         (task_count_r),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_total_cost     (out_chan.total_cost),
    .out_index_error    (out_chan.index_error),
    .out_cost_saturated (out_chan.cost_saturated)
  );

endmodule
